### hdl/tlbs_pkg.sv
// Shared types and constants for the table search block.
// No dependencies; imported by every module of the block except tlbs_ram.
`default_nettype none

package tlbs_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam int WORD_W          = 32;
    localparam int INDEX_W         = 4;
    localparam int COUNT_W         = 5;
    localparam int POS_W           = 5;
    localparam int FUNC_W          = 2;
    localparam int STATUS_W        = 2;
    localparam int S_DATA_W        = 40;
    localparam int M_DATA_W        = 8;

    localparam logic [COUNT_W-1:0] ENTRY_COUNT_RST = 5'd10;

    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LINEAR  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_BINARY  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_INVALID = 2'd3;

    localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_LINEAR,
        CMD_BINARY,
        CMD_INVALID
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [INDEX_W-1:0]  index;
        logic [WORD_W-1:0]   value;
    } cmd_t;

endpackage

`default_nettype wire

### hdl/tlbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tlbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/tlbs_queue.sv
// Short command FIFO between the front decoder and the search engine.
// Depends on tlbs_pkg (cmd_t).
`default_nettype none

module tlbs_queue
    import tlbs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_data,
    output logic      full,
    input  wire logic pop,
    output logic      valid,
    output cmd_t      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign valid    = (count_reg != '0);
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### hdl/tlbs_front.sv
// Input decoder: unpacks the slave word, classifies it and queues a command.
// Depends on tlbs_pkg (cmd_t, function codes).
`default_nettype none

module tlbs_front
    import tlbs_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic [FUNC_W-1:0]   s_tuser,
    input  wire logic                q_full,
    output logic                     q_push,
    output cmd_t                     q_cmd
);

    logic [INDEX_W-1:0] index;
    logic               index_ok;
    logic               drop;

    assign index    = s_tdata[INDEX_W-1:0];
    assign index_ok = (32'(index) < 32'(TABLE_DEPTH));
    assign s_tready = !q_full;

    always_comb
    begin
        q_cmd.index = index;
        q_cmd.value = s_tdata[INDEX_W +: WORD_W];
        drop        = 1'b0;
        unique case (s_tuser)
            FUNC_LOAD:
            begin
                q_cmd.kind = CMD_LOAD;
                drop       = !index_ok;
            end
            FUNC_LINEAR:  q_cmd.kind = CMD_LINEAR;
            FUNC_BINARY:  q_cmd.kind = CMD_BINARY;
            FUNC_INVALID: q_cmd.kind = CMD_INVALID;
            default:      q_cmd.kind = CMD_INVALID;
        endcase
    end

    // out-of-range loads are accepted and discarded here
    assign q_push = s_tvalid && s_tready && !drop;

endmodule

`default_nettype wire

### hdl/tlbs_back.sv
// Search engine: executes loads, linear and binary searches over the table RAM
// and drives the registered result word. Depends on tlbs_pkg.
`default_nettype none

module tlbs_back
    import tlbs_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [COUNT_W-1:0]  entry_count,
    input  wire logic                q_valid,
    input  wire cmd_t                q_cmd,
    output logic                     q_pop,
    output logic                     ram_we,
    output logic [ADDR_W-1:0]        ram_waddr,
    output logic [WORD_W-1:0]        ram_wdata,
    output logic [ADDR_W-1:0]        ram_raddr,
    input  wire logic [WORD_W-1:0]   ram_rdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,  // [4:0] position
    output logic                     m_tlast,
    output logic [STATUS_W-1:0]      m_tuser   // [1:0] status
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LIN  = 4'b0010,
        S_BIN  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    function automatic logic [ADDR_W-1:0] to_addr(input logic [COUNT_W-1:0] x);
        logic [31:0] e;
        e = 32'(x);
        return e[ADDR_W-1:0];
    endfunction

    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   idx_reg, idx_next;
    logic [COUNT_W-1:0]   low_reg, low_next;
    logic signed [COUNT_W:0] high_reg, high_next;
    logic [WORD_W-1:0]    val_reg, val_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [POS_W-1:0]     pend_pos_reg, pend_pos_next;
    logic [STATUS_W-1:0]  fin_status_reg, fin_status_next;
    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [POS_W-1:0]     out_pos_reg, out_pos_next;
    logic                 out_last_reg, out_last_next;

    logic [COUNT_W-1:0]   n_used;
    logic                 out_free;
    logic                 match, less;
    logic [COUNT_W-1:0]   new_low;
    logic signed [COUNT_W:0] new_high;
    logic [COUNT_W:0]     mid_sum;
    logic                 emit;
    logic [STATUS_W-1:0]  emit_status;
    logic [POS_W-1:0]     emit_pos;
    logic                 emit_last;

    assign n_used   = (32'(entry_count) > 32'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH)
                                                            : entry_count;
    assign out_free = !out_valid_reg || m_tready;
    assign match    = (ram_rdata == val_reg);
    assign less     = ($signed(ram_rdata) < $signed(val_reg));
    assign new_low  = less ? idx_reg + 1'b1 : low_reg;
    assign new_high = less ? high_reg : $signed({1'b0, idx_reg}) - 6'sd1;
    assign mid_sum  = {1'b0, new_low} + {1'b0, new_high[COUNT_W-1:0]};

    assign ram_waddr = to_addr({1'b0, q_cmd.index});
    assign ram_wdata = q_cmd.value;
    // read address follows the next index so rdata matches idx_reg
    assign ram_raddr = to_addr(idx_next);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        val_next        = val_reg;
        pend_valid_next = pend_valid_reg;
        pend_pos_next   = pend_pos_reg;
        fin_status_next = fin_status_reg;
        q_pop           = 1'b0;
        ram_we          = 1'b0;
        emit            = 1'b0;
        emit_status     = ST_FOUND;
        emit_pos        = '0;
        emit_last       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop           = 1'b1;
                    val_next        = q_cmd.value;
                    pend_valid_next = 1'b0;
                    fin_status_next = ST_NOTFOUND;
                    unique case (q_cmd.kind)
                        CMD_LOAD:
                        begin
                            ram_we = 1'b1;
                        end
                        CMD_LINEAR:
                        begin
                            idx_next   = '0;
                            state_next = (n_used == '0) ? S_FIN : S_LIN;
                        end
                        CMD_BINARY:
                        begin
                            low_next   = '0;
                            high_next  = $signed({1'b0, n_used}) - 6'sd1;
                            idx_next   = (n_used - 1'b1) >> 1;
                            state_next = (n_used == '0) ? S_FIN : S_BIN;
                        end
                        CMD_INVALID:
                        begin
                            fin_status_next = ST_INVALID;
                            state_next      = S_FIN;
                        end
                        default:
                        begin
                            fin_status_next = ST_INVALID;
                            state_next      = S_FIN;
                        end
                    endcase
                end
            end
            S_LIN:
            begin
                // a new match pushes out the held one, which then is not last
                if (!(match && pend_valid_reg && !out_free))
                begin
                    if (match)
                    begin
                        emit            = pend_valid_reg;
                        emit_status     = ST_FOUND;
                        emit_pos        = pend_pos_reg;
                        emit_last       = 1'b0;
                        pend_valid_next = 1'b1;
                        pend_pos_next   = idx_reg + 1'b1;
                    end
                    if (idx_reg == n_used - 1'b1)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_BIN:
            begin
                if (match)
                begin
                    pend_valid_next = 1'b1;
                    pend_pos_next   = idx_reg + 1'b1;
                    state_next      = S_FIN;
                end
                else if ($signed({1'b0, new_low}) > new_high)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    low_next  = new_low;
                    high_next = new_high;
                    idx_next  = mid_sum[COUNT_W:1];
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_status = pend_valid_reg ? ST_FOUND : fin_status_reg;
                    emit_pos    = pend_valid_reg ? pend_pos_reg : '0;
                    emit_last   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_last_next   = out_last_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = emit_status;
            out_pos_next    = emit_pos;
            out_last_next   = emit_last;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        low_reg        <= low_next;
        high_reg       <= high_next;
        val_reg        <= val_next;
        pend_pos_reg   <= pend_pos_next;
        fin_status_reg <= fin_status_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_pos_reg);
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

endmodule

`default_nettype wire

### hdl/table_linear_binary_search_top.sv
// Table search block: a linear search reads one table entry per cycle through
// the single RAM read port, except while a new match waits on a stalled result
// output. Items run one at a time; a stalled result output holds up the item in
// progress. The command queue holds 2 words.
// Reset clears control state and sets entry_count to 10; table contents stay
// undefined until loaded.
`default_nettype none

module table_linear_binary_search_top
    import tlbs_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,  // [3:0] entry_index, [35:4] data_value
    input  wire logic [FUNC_W-1:0]   s_tuser,  // [1:0] func
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,  // [4:0] position
    output logic                     m_tlast,
    output logic [STATUS_W-1:0]      m_tuser,  // [1:0] status
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [COUNT_W-1:0]  cfg_data
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [COUNT_W-1:0] entry_count_reg;
    logic               q_full, q_push, q_valid, q_pop;
    cmd_t               front_cmd, back_cmd;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [WORD_W-1:0]  ram_wdata, ram_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= ENTRY_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            entry_count_reg <= cfg_data;
        end
    end

    tlbs_front #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (front_cmd)
    );

    tlbs_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (back_cmd)
    );

    tlbs_back #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_count (entry_count_reg),
        .q_valid     (q_valid),
        .q_cmd       (back_cmd),
        .q_pop       (q_pop),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    tlbs_ram #(
        .WIDTH(WORD_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

### hdl/tlbs_chk.sv
// Port-level checker for the table search block, bound to the top level.
// Depends on tlbs_pkg (status codes, widths).
`default_nettype none

module tlbs_chk
    import tlbs_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic                m_tlast,
    input wire logic [STATUS_W-1:0] m_tuser
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result word changed while stalled");

    a_miss_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_FOUND) |-> m_tlast && (m_tdata == '0))
        else $error("not-found or invalid result must be last with position 0");

    a_hit_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_FOUND) |-> (m_tdata != '0))
        else $error("found result with position 0");

endmodule

bind table_linear_binary_search_top tlbs_chk u_chk (.*);

`default_nettype wire

### bench/testbench.sv
// Stream-level bench for table_linear_binary_search_top: loads, linear and binary
// searches over several entry_count settings, checked against an in-bench table search.
// Depends on tlbs_pkg and the RTL under hdl/.
module testbench;
    import tlbs_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic                last;
    } search_result_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic [FUNC_W-1:0]   s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic [STATUS_W-1:0] m_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [COUNT_W-1:0]  cfg_data  = '0;

    cmd_t           cmd_backlog[$];
    search_result_t search_results_due[$];

    // in-bench copy of the table, updated as words are accepted
    logic signed [WORD_W-1:0] table_words[16];
    logic [COUNT_W-1:0]       table_count = ENTRY_COUNT_RST;
    // generator's view of the table, updated as words are queued
    logic signed [WORD_W-1:0] gen_words[16];
    logic [COUNT_W-1:0]       gen_count = ENTRY_COUNT_RST;

    int   mismatch_count = 0;
    int   words_in       = 0;
    int   gap_left       = 0;
    int   burst_left     = 0;
    int   ready_mode     = 0;
    int   ready_cycle    = 0;
    logic hold_off       = 1'b0;
    cmd_t drive_cmd;

    table_linear_binary_search_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void queue_cmd(cmd_kind_t kind, logic [INDEX_W-1:0] idx,
                                      logic [WORD_W-1:0] val);
        cmd_t c;
        c.kind  = kind;
        c.index = idx;
        c.value = val;
        cmd_backlog.push_back(c);
        if (kind == CMD_LOAD)
            gen_words[idx] = val;
    endfunction

    function automatic void search_outcome(cmd_kind_t kind, logic [INDEX_W-1:0] idx,
                                           logic signed [WORD_W-1:0] val);
        search_result_t r;
        int used;
        int lo;
        int hi;
        int mid;
        int hits;
        logic [POS_W-1:0] hit_pos[16];
        used = (table_count > 16) ? 16 : int'(table_count);
        case (kind)
            CMD_LOAD:
                table_words[idx] = val;
            CMD_LINEAR:
            begin
                hits = 0;
                for (int i = 0; i < used; i++)
                begin
                    if (table_words[i] == val)
                    begin
                        hit_pos[hits] = POS_W'(i + 1);
                        hits++;
                    end
                end
                if (hits == 0)
                begin
                    r = '{ST_NOTFOUND, '0, 1'b1};
                    search_results_due.push_back(r);
                end
                for (int k = 0; k < hits; k++)
                begin
                    r = '{ST_FOUND, hit_pos[k], k == hits - 1};
                    search_results_due.push_back(r);
                end
            end
            CMD_BINARY:
            begin
                lo = 0;
                hi = used - 1;
                r = '{ST_NOTFOUND, '0, 1'b1};
                while (lo <= hi)
                begin
                    mid = lo + (hi - lo) / 2;
                    if (table_words[mid] == val)
                    begin
                        r = '{ST_FOUND, POS_W'(mid + 1), 1'b1};
                        break;
                    end
                    else if (table_words[mid] < val)
                        lo = mid + 1;
                    else
                        hi = mid - 1;
                end
                search_results_due.push_back(r);
            end
            default:
            begin
                r = '{ST_INVALID, '0, 1'b1};
                search_results_due.push_back(r);
            end
        endcase
    endfunction

    // sender: bursts of words with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (cmd_backlog.size() > 0)
            begin
                drive_cmd = cmd_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {4'b0, drive_cmd.value, drive_cmd.index};
                s_tuser  <= drive_cmd.kind;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left = burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: stall pattern is redrawn at random from four modes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            ready_cycle = ready_cycle + 1;
            if (ready_cycle == 64)
            begin
                ready_cycle = 0;
                ready_mode  = $urandom_range(0, 3);
            end
            if (hold_off)
                m_tready <= 1'b0;
            else
                case (ready_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    2: m_tready <= (ready_cycle % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
        end
    end

    // long hold-off so the command queue fills and s_tready drops
    initial
    begin
        while (words_in < 18)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        search_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                words_in++;
                search_outcome(cmd_kind_t'(s_tuser), s_tdata[3:0], s_tdata[35:4]);
            end
            if (m_tvalid && m_tready)
            begin
                if (search_results_due.size() == 0)
                begin
                    $error("unexpected result word: status %0d position %0d last %0d",
                           m_tuser, m_tdata[4:0], m_tlast);
                    mismatch_count++;
                end
                else
                begin
                    want = search_results_due.pop_front();
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        mismatch_count++;
                    end
                    if (m_tdata[4:0] !== want.position)
                    begin
                        $error("position: expected %0d, got %0d", want.position, m_tdata[4:0]);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_result: expected %0d, got %0d", want.last, m_tlast);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || s_tvalid || search_results_due.size() != 0)
            @(posedge clk);
        // loads leave no result; give the engine time to finish them
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        logic signed [WORD_W-1:0] sorted_init[16];
        logic [COUNT_W-1:0]       count_plan[9];
        logic [WORD_W-1:0]        v;
        longint                   acc;
        int                       used;
        int                       r;
        sorted_init = '{32'sh8000_0000, -1000000, -5, -1, 0, 0, 0, 1, 7, 42, 42,
                        1000, 65535, 123456789, 32'sh7fff_fffe, 32'sh7fff_ffff};
        count_plan = '{5'd16, 5'd0, 5'd31, 5'd17, 5'd1, 5'd2,
                       COUNT_W'($urandom_range(3, 15)), COUNT_W'($urandom_range(0, 31)),
                       5'd10};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 16; i++)
            queue_cmd(CMD_LOAD, INDEX_W'(i), sorted_init[i]);
        queue_cmd(CMD_LINEAR, 4'd0, 0);
        queue_cmd(CMD_LINEAR, 4'd15, 42);
        queue_cmd(CMD_LINEAR, 4'd3, 32'sh8000_0000);
        queue_cmd(CMD_LINEAR, 4'd0, 32'sh7fff_ffff);
        queue_cmd(CMD_BINARY, 4'd0, 42);
        queue_cmd(CMD_BINARY, 4'd0, 0);
        queue_cmd(CMD_BINARY, 4'd9, -5);
        queue_cmd(CMD_BINARY, 4'd0, 3);
        queue_cmd(CMD_BINARY, 4'd0, 32'sh8000_0000);
        queue_cmd(CMD_INVALID, 4'd15, 32'sh7fff_ffff);

        for (int p = 0; p < 9; p++)
        begin
            wait_idle();
            @(posedge clk);
            cfg_valid <= 1'b1;
            cfg_data  <= count_plan[p];
            do
                @(posedge clk);
            while (!cfg_ready);
            cfg_valid   <= 1'b0;
            table_count = count_plan[p];
            gen_count   = count_plan[p];
            used = (gen_count > 16) ? 16 : int'(gen_count);

            // fresh ascending table so binary searches walk deep
            if (p % 2 == 0)
            begin
                acc = -64'sd2147483648 + longint'($urandom_range(0, 1 << 30));
                for (int i = 0; i < 16; i++)
                begin
                    if (acc > 64'sd2147483647)
                        acc = 64'sd2147483647;
                    queue_cmd(CMD_LOAD, INDEX_W'(i), acc[31:0]);
                    if ($urandom_range(0, 3) != 0)
                        acc += longint'($urandom_range(1, 1 << 28));
                end
            end

            for (int n = 0; n < 6; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 20)
                begin
                    v = ($urandom_range(0, 4) < 2) ? WORD_W'($urandom_range(0, 8) - 4)
                                                   : WORD_W'($urandom);
                    queue_cmd(CMD_LOAD, INDEX_W'($urandom_range(0, 15)), v);
                end
                else if (r < 92)
                begin
                    case ($urandom_range(0, 19))
                        0, 1:    v = 32'h8000_0000;
                        2, 3:    v = 32'h7fff_ffff;
                        4, 5, 6, 7, 8: v = $urandom;
                        default: v = gen_words[$urandom_range(0, (used > 0) ? used - 1 : 15)];
                    endcase
                    queue_cmd((r < 55) ? CMD_LINEAR : CMD_BINARY,
                              INDEX_W'($urandom_range(0, 15)), v);
                end
                else
                    queue_cmd(CMD_INVALID, INDEX_W'($urandom_range(0, 15)), $urandom);
            end
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("** table_linear_binary_search_top: PASSED **");
        else
            $display("** table_linear_binary_search_top: FAILED **");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("** table_linear_binary_search_top: FAILED **");
        $finish;
    end

endmodule
